// ----- rtl/core/command_line_tokenizer_top_assert.svh -----
// Assertion macros shared by the command line tokenizer RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define CLT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("command line tokenizer check failed");

// Consequent holds in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("command line tokenizer check failed");

`else

`define CLT_ASSERT(lbl, clk, rstn, prop)
`define CLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/clt_pkg.sv -----
// Types and constants of the command line tokenizer.
// No dependencies; used by clt_core, clt_out_queue and the top module under rtl/core.
package clt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_OPEN_APOS  = 3'd1,
        ERR_OPEN_QUOTE = 3'd2,
        ERR_DANGLING   = 3'd3,
        ERR_TOO_MANY   = 3'd4,
        ERR_TOO_LONG   = 3'd5
    } err_t;

    typedef struct packed {
        logic       write_valid;
        logic [8:0] write_position;
        logic [7:0] write_byte;
        logic       starts_token;
        logic [5:0] token_index;
        logic [6:0] token_count;
        logic       line_done;
        err_t       error_code;
        logic       last;
    } res_t;

    // push request from the tokenizer core into the result queue
    typedef struct packed {
        logic valid;
        logic two;
    } push_t;

endpackage

// ----- rtl/core/clt_in_stage.sv -----
// Input register of the command line tokenizer.
// Depends on nothing but the clock and reset.
module clt_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    assign s_tready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

// ----- rtl/core/clt_core.sv -----
// Tokenizer state and per-byte decode; yields one or two results per byte.
// Depends on clt_pkg and the assertion macro header.
`include "command_line_tokenizer_top_assert.svh"

module clt_core #(
    parameter int MAX_TOKENS = 64,
    parameter int MAX_LINE   = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              room,
    output logic              take,
    output clt_pkg::push_t    push,
    output clt_pkg::res_t     res0,
    output clt_pkg::res_t     res1
);

    localparam int WP_W = $clog2(MAX_LINE + 2);
    localparam int TC_W = $clog2(MAX_TOKENS + 1);
    localparam logic [WP_W-1:0] WP_MAX   = WP_W'(MAX_LINE);
    localparam logic [WP_W-1:0] WP_LIMIT = WP_W'(MAX_LINE + 1);
    localparam logic [TC_W-1:0] TC_MAX   = TC_W'(MAX_TOKENS);

    logic            between_reg, between_next;
    logic            sq_reg, sq_next;
    logic            dq_reg, dq_next;
    logic            esc_reg, esc_next;
    logic [WP_W-1:0] wp_reg, wp_next;
    logic [TC_W-1:0] tc_reg, tc_next;

    logic            lit_req;
    logic            fail_req;
    clt_pkg::err_t   fail_code;
    logic            two;
    logic            clear;

    assign take = in_valid && room;

    always_comb begin
        between_next = between_reg;
        sq_next      = sq_reg;
        dq_next      = dq_reg;
        esc_next     = esc_reg;
        wp_next      = wp_reg;
        tc_next      = tc_reg;
        lit_req      = 1'b0;
        fail_req     = 1'b0;
        fail_code    = clt_pkg::ERR_NONE;
        two          = 1'b0;
        clear        = 1'b0;

        res0             = '0;
        res0.token_count = 7'(tc_reg);
        res0.error_code  = clt_pkg::ERR_NONE;
        res0.last        = 1'b1;
        res1             = '0;
        res1.token_count = 7'(tc_reg);
        res1.error_code  = clt_pkg::ERR_NONE;
        res1.last        = 1'b1;

        if (esc_reg) begin
            esc_next = 1'b0;
            if (in_byte == clt_pkg::CH_NUL) begin
                fail_req  = 1'b1;
                fail_code = clt_pkg::ERR_DANGLING;
            end else begin
                lit_req = 1'b1;
            end
        end else begin
            unique case (in_byte)
                clt_pkg::CH_NUL: begin
                    if (sq_reg) begin
                        fail_req  = 1'b1;
                        fail_code = clt_pkg::ERR_OPEN_APOS;
                    end else if (dq_reg) begin
                        fail_req  = 1'b1;
                        fail_code = clt_pkg::ERR_OPEN_QUOTE;
                    end else if (!between_reg) begin
                        // token terminator, then the line-end NUL
                        two                 = 1'b1;
                        res0.write_valid    = 1'b1;
                        res0.write_position = 9'(wp_reg);
                        res0.token_index    = 6'(tc_reg - TC_W'(1));
                        res0.line_done      = 1'b1;
                        res0.last           = 1'b0;
                        res1.write_valid    = 1'b1;
                        res1.write_position = 9'(wp_reg + WP_W'(1));
                        res1.line_done      = 1'b1;
                        clear               = 1'b1;
                    end else begin
                        res0.write_valid    = 1'b1;
                        res0.write_position = 9'(wp_reg);
                        res0.line_done      = 1'b1;
                        clear               = 1'b1;
                    end
                end
                clt_pkg::CH_SPACE: begin
                    if (sq_reg || dq_reg) begin
                        lit_req = 1'b1;
                    end else if (!between_reg) begin
                        if (wp_reg > WP_MAX) begin
                            fail_req  = 1'b1;
                            fail_code = clt_pkg::ERR_TOO_LONG;
                        end else begin
                            res0.write_valid    = 1'b1;
                            res0.write_position = 9'(wp_reg);
                            res0.token_index    = 6'(tc_reg - TC_W'(1));
                            wp_next             = wp_reg + WP_W'(1);
                            between_next        = 1'b1;
                        end
                    end
                end
                clt_pkg::CH_BSL: begin
                    esc_next = 1'b1;
                end
                clt_pkg::CH_APOS: begin
                    if (dq_reg) begin
                        lit_req = 1'b1;
                    end else begin
                        sq_next = !sq_reg;
                    end
                end
                clt_pkg::CH_QUOTE: begin
                    if (sq_reg) begin
                        lit_req = 1'b1;
                    end else begin
                        dq_next = !dq_reg;
                    end
                end
                default: begin
                    lit_req = 1'b1;
                end
            endcase
        end

        // literal byte: count check first, then length check
        if (lit_req) begin
            if (between_reg && (tc_reg >= TC_MAX)) begin
                fail_req  = 1'b1;
                fail_code = clt_pkg::ERR_TOO_MANY;
            end else if (wp_reg >= WP_MAX) begin
                fail_req  = 1'b1;
                fail_code = clt_pkg::ERR_TOO_LONG;
            end else begin
                res0.write_valid    = 1'b1;
                res0.write_position = 9'(wp_reg);
                res0.write_byte     = in_byte;
                wp_next             = wp_reg + WP_W'(1);
                if (between_reg) begin
                    res0.starts_token = 1'b1;
                    res0.token_index  = 6'(tc_reg);
                    res0.token_count  = 7'(tc_reg + TC_W'(1));
                    tc_next           = tc_reg + TC_W'(1);
                    between_next      = 1'b0;
                end else begin
                    res0.token_index  = 6'(tc_reg - TC_W'(1));
                end
            end
        end

        if (fail_req) begin
            res0             = '0;
            res0.token_count = 7'(tc_reg);
            res0.line_done   = 1'b1;
            res0.error_code  = fail_code;
            res0.last        = 1'b1;
            clear            = 1'b1;
        end

        // drop all line state after line end or error
        if (clear) begin
            between_next = 1'b1;
            sq_next      = 1'b0;
            dq_next      = 1'b0;
            esc_next     = 1'b0;
            wp_next      = '0;
            tc_next      = '0;
        end

        push.valid = take;
        push.two   = two;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            between_reg <= 1'b1;
            sq_reg      <= 1'b0;
            dq_reg      <= 1'b0;
            esc_reg     <= 1'b0;
            wp_reg      <= '0;
            tc_reg      <= '0;
        end else if (take) begin
            between_reg <= between_next;
            sq_reg      <= sq_next;
            dq_reg      <= dq_next;
            esc_reg     <= esc_next;
            wp_reg      <= wp_next;
            tc_reg      <= tc_next;
        end
    end

    `CLT_ASSERT(a_quotes_exclusive, aclk, aresetn, !(sq_reg && dq_reg))
    `CLT_ASSERT(a_token_bound, aclk, aresetn, tc_reg <= TC_MAX)
    `CLT_ASSERT(a_pointer_bound, aclk, aresetn, wp_reg <= WP_LIMIT)
    `CLT_ASSERT_NEXT(a_line_clears, aclk, aresetn, take && res0.line_done,
                     wp_reg == '0 && tc_reg == '0 && between_reg && !esc_reg)

endmodule

// ----- rtl/core/clt_out_queue.sv -----
// Result queue of the command line tokenizer: two pushes, one pop per cycle.
// Depends on clt_pkg and the assertion macro header.
`include "command_line_tokenizer_top_assert.svh"

module clt_out_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  clt_pkg::push_t  push,
    input  clt_pkg::res_t   din0,
    input  clt_pkg::res_t   din1,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output clt_pkg::res_t   head
);

    localparam int AW = clt_pkg::OQ_AW;
    localparam logic [AW:0] DEPTH   = (AW+1)'(clt_pkg::OQ_DEPTH);
    localparam logic [AW:0] ROOM_AT = (AW+1)'(clt_pkg::OQ_DEPTH - 2);

    clt_pkg::res_t   mem [clt_pkg::OQ_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            pop;
    logic [AW:0]     n_push;

    assign room      = count_reg <= ROOM_AT;
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        n_push = '0;
        if (push.valid) begin
            n_push = push.two ? (AW+1)'(2) : (AW+1)'(1);
        end
        wr_ptr_next = wr_ptr_reg + n_push[AW-1:0];
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + n_push - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= din0;
            if (push.two) begin
                mem[wr_ptr_reg + AW'(1)] <= din1;
            end
        end
    end

    `CLT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= DEPTH)
    `CLT_ASSERT(a_push_has_room, aclk, aresetn, !push.valid || count_reg <= ROOM_AT)
    `CLT_ASSERT_NEXT(a_count_holds, aclk, aresetn, !push.valid && !pop, $stable(count_reg))

endmodule

// ----- rtl/core/command_line_tokenizer_top.sv -----
// Command line tokenizer top: input register, tokenizer core, result queue.
// A byte passes the input register and the core into the 4-entry result queue.
// Throughput: one byte per cycle while the queue has room; a line end after a
// token emits two beats, so the result side paces at one beat per ready cycle.
// Reset (aresetn low, synchronous) empties the queue and starts a fresh line.
module command_line_tokenizer_top #(
    parameter int MAX_TOKENS = 64,
    parameter int MAX_LINE   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] write_position, [16:9] write_byte, [22:17] token_index,
    // [29:23] token_count, [32:30] error_code, [39:33] zero
    output logic [39:0] m_tdata,
    // [0] write_valid, [1] starts_token, [2] line_done
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic           in_valid;
    logic [7:0]     in_byte;
    logic           take;
    logic           room;
    clt_pkg::push_t push;
    clt_pkg::res_t  res0;
    clt_pkg::res_t  res1;
    clt_pkg::res_t  head;

    clt_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    clt_core #(
        .MAX_TOKENS (MAX_TOKENS),
        .MAX_LINE   (MAX_LINE)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .room     (room),
        .take     (take),
        .push     (push),
        .res0     (res0),
        .res1     (res1)
    );

    clt_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din0      (res0),
        .din1      (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {7'b0, head.error_code, head.token_count, head.token_index,
                      head.write_byte, head.write_position};
    assign m_tuser = {head.line_done, head.starts_token, head.write_valid};
    assign m_tlast = head.last;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for command_line_tokenizer_top: streams command lines into the
// block and compares every result beat against an in-bench model of the tokenizer.
// Depends on clt_pkg (character codes, err_t, res_t) and the RTL under rtl/core.
module tb_top;

    localparam int MAX_TOKENS = 64;
    localparam int MAX_LINE   = 256;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    // [8:0] write_position, [16:9] write_byte, [22:17] token_index,
    // [29:23] token_count, [32:30] error_code, [39:33] zero
    logic [39:0] m_tdata;
    // [0] write_valid, [1] starts_token, [2] line_done
    logic [2:0]  m_tuser;
    logic        m_tlast;

    command_line_tokenizer_top #(
        .MAX_TOKENS(MAX_TOKENS),
        .MAX_LINE  (MAX_LINE)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // tokenizer state mirrored for prediction
    bit at_gap;
    bit in_apos;
    bit in_quote;
    bit escaped;
    int wr_ptr;
    int tok_cnt;

    clt_pkg::res_t expected_writes[$];
    logic [7:0]    line_q[$];
    int            mismatch_count = 0;
    bit            idle_on = 1'b0;
    int            stall_left = 0;

    function automatic void clear_line_state();
        at_gap   = 1'b1;
        in_apos  = 1'b0;
        in_quote = 1'b0;
        escaped  = 1'b0;
        wr_ptr   = 0;
        tok_cnt  = 0;
    endfunction

    function automatic void expect_write(bit valid, int pos, logic [7:0] ch, bit starts,
                                         int tidx, bit done, clt_pkg::err_t err, bit lst);
        clt_pkg::res_t r;
        r.write_valid    = valid;
        r.write_position = valid ? pos[8:0] : 9'd0;
        r.write_byte     = valid ? ch : 8'd0;
        r.starts_token   = valid && starts;
        r.token_index    = valid ? tidx[5:0] : 6'd0;
        r.token_count    = tok_cnt[6:0];
        r.line_done      = done;
        r.error_code     = err;
        r.last           = lst;
        expected_writes.push_back(r);
    endfunction

    function automatic void abort_line(clt_pkg::err_t err);
        expect_write(1'b0, 0, 8'd0, 1'b0, 0, 1'b1, err, 1'b1);
        clear_line_state();
    endfunction

    function automatic void expect_no_write();
        expect_write(1'b0, 0, 8'd0, 1'b0, 0, 1'b0, clt_pkg::ERR_NONE, 1'b1);
    endfunction

    function automatic void token_char(logic [7:0] ch);
        bit starts;
        starts = 1'b0;
        if (at_gap) begin
            if (tok_cnt >= MAX_TOKENS) begin
                abort_line(clt_pkg::ERR_TOO_MANY);
                return;
            end
            starts = 1'b1;
        end
        if (wr_ptr >= MAX_LINE) begin
            abort_line(clt_pkg::ERR_TOO_LONG);
            return;
        end
        if (starts) begin
            tok_cnt++;
            at_gap = 1'b0;
        end
        expect_write(1'b1, wr_ptr, ch, starts, tok_cnt - 1, 1'b0, clt_pkg::ERR_NONE, 1'b1);
        wr_ptr++;
    endfunction

    function automatic void tokenize_byte(logic [7:0] ch);
        if (escaped) begin
            escaped = 1'b0;
            if (ch == clt_pkg::CH_NUL)
                abort_line(clt_pkg::ERR_DANGLING);
            else
                token_char(ch);
            return;
        end
        case (ch)
            clt_pkg::CH_NUL: begin
                if (in_apos) begin
                    abort_line(clt_pkg::ERR_OPEN_APOS);
                end else if (in_quote) begin
                    abort_line(clt_pkg::ERR_OPEN_QUOTE);
                end else begin
                    // terminate the open token, then the extra NUL of the line
                    if (!at_gap) begin
                        expect_write(1'b1, wr_ptr, clt_pkg::CH_NUL, 1'b0, tok_cnt - 1,
                                     1'b1, clt_pkg::ERR_NONE, 1'b0);
                        wr_ptr++;
                    end
                    expect_write(1'b1, wr_ptr, clt_pkg::CH_NUL, 1'b0, 0, 1'b1,
                                 clt_pkg::ERR_NONE, 1'b1);
                    clear_line_state();
                end
            end
            clt_pkg::CH_SPACE: begin
                if (in_apos || in_quote) begin
                    token_char(ch);
                end else if (at_gap) begin
                    expect_no_write();
                end else if (wr_ptr > MAX_LINE) begin
                    abort_line(clt_pkg::ERR_TOO_LONG);
                end else begin
                    expect_write(1'b1, wr_ptr, clt_pkg::CH_NUL, 1'b0, tok_cnt - 1, 1'b0,
                                 clt_pkg::ERR_NONE, 1'b1);
                    wr_ptr++;
                    at_gap = 1'b1;
                end
            end
            clt_pkg::CH_BSL: begin
                escaped = 1'b1;
                expect_no_write();
            end
            clt_pkg::CH_APOS: begin
                if (in_quote) begin
                    token_char(ch);
                end else begin
                    in_apos = !in_apos;
                    expect_no_write();
                end
            end
            clt_pkg::CH_QUOTE: begin
                if (in_apos) begin
                    token_char(ch);
                end else begin
                    in_quote = !in_quote;
                    expect_no_write();
                end
            end
            default: token_char(ch);
        endcase
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_write_beat();
        clt_pkg::res_t want;
        if (expected_writes.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual tdata=%h tuser=%b tlast=%b",
                     $time, m_tdata, m_tuser, m_tlast);
            mismatch_count++;
            return;
        end
        want = expected_writes.pop_front();
        compare_field("write_valid", want.write_valid, m_tuser[0]);
        compare_field("write_position", want.write_position, m_tdata[8:0]);
        compare_field("write_byte", want.write_byte, m_tdata[16:9]);
        compare_field("starts_token", want.starts_token, m_tuser[1]);
        compare_field("token_index", want.token_index, m_tdata[22:17]);
        compare_field("token_count", want.token_count, m_tdata[29:23]);
        compare_field("line_done", want.line_done, m_tuser[2]);
        compare_field("error_code", want.error_code, m_tdata[32:30]);
        compare_field("last", want.last, m_tlast);
    endfunction

    // check accepted beats and throttle m_tready in bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_write_beat();
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] ch);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tokenize_byte(ch);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        line_q.delete();
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (ch == clt_pkg::CH_SPACE || ch == clt_pkg::CH_APOS ||
               ch == clt_pkg::CH_QUOTE || ch == clt_pkg::CH_BSL);
        return ch;
    endfunction

    function automatic logic [7:0] quoted_char(logic [7:0] closer);
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (ch == closer || ch == clt_pkg::CH_BSL);
        return ch;
    endfunction

    // append one well-formed token built from plain runs, quoted runs and escapes
    function automatic void build_token();
        int pieces;
        int len;
        logic [7:0] closer;
        pieces = $urandom_range(1, 4);
        repeat (pieces) begin
            len = $urandom_range(0, 5);
            case ($urandom_range(0, 3))
                0: repeat (len + 1) line_q.push_back(plain_char());
                1, 2: begin
                    closer = ($urandom_range(0, 1) != 0) ? clt_pkg::CH_APOS
                                                         : clt_pkg::CH_QUOTE;
                    line_q.push_back(closer);
                    repeat (len) begin
                        if ($urandom_range(0, 7) == 0) begin
                            line_q.push_back(clt_pkg::CH_BSL);
                            line_q.push_back(8'($urandom_range(1, 255)));
                        end else begin
                            line_q.push_back(quoted_char(closer));
                        end
                    end
                    line_q.push_back(closer);
                end
                default: begin
                    line_q.push_back(clt_pkg::CH_BSL);
                    line_q.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
    endfunction

    function automatic void build_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) line_q.push_back(clt_pkg::CH_SPACE);
    endfunction

    task automatic test_directed_lines();
        // two tokens with extreme bytes, trailing space
        line_q = '{8'h01, clt_pkg::CH_SPACE, 8'hFF, clt_pkg::CH_SPACE, clt_pkg::CH_NUL};
        send_line();
        // double quote and space literal inside apostrophes, then an open quote
        line_q = '{clt_pkg::CH_APOS, clt_pkg::CH_QUOTE, clt_pkg::CH_SPACE,
                   clt_pkg::CH_APOS, clt_pkg::CH_QUOTE, clt_pkg::CH_NUL};
        send_line();
        // apostrophe literal inside quotes
        line_q = '{clt_pkg::CH_QUOTE, clt_pkg::CH_APOS, clt_pkg::CH_QUOTE, clt_pkg::CH_NUL};
        send_line();
        // escaped space and escaped backslash
        line_q = '{clt_pkg::CH_BSL, clt_pkg::CH_SPACE, clt_pkg::CH_BSL, clt_pkg::CH_BSL,
                   clt_pkg::CH_NUL};
        send_line();
        line_q = '{clt_pkg::CH_APOS, clt_pkg::CH_NUL};
        send_line();
        line_q = '{clt_pkg::CH_BSL, clt_pkg::CH_NUL};
        send_line();
        line_q = '{clt_pkg::CH_NUL};
        send_line();
    endtask

    task automatic test_random_lines(int n_bytes, bit with_idle);
        int sent;
        int ntok;
        sent = 0;
        while (sent < n_bytes) begin
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            ntok = $urandom_range(0, 6);
            build_spaces(0, 2);
            for (int t = 0; t < ntok; t++) begin
                build_token();
                if (t != ntok - 1 || $urandom_range(0, 3) == 0)
                    build_spaces(1, 3);
            end
            if ($urandom_range(0, 4) == 0) begin
                // broken tail: unterminated quote, dangling escape or raw noise
                case ($urandom_range(0, 3))
                    0: begin
                        line_q.push_back(clt_pkg::CH_APOS);
                        line_q.push_back(plain_char());
                    end
                    1: begin
                        line_q.push_back(clt_pkg::CH_QUOTE);
                        line_q.push_back(plain_char());
                    end
                    2: line_q.push_back(clt_pkg::CH_BSL);
                    default: repeat ($urandom_range(1, 20))
                        line_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            line_q.push_back(clt_pkg::CH_NUL);
            sent += line_q.size();
            send_line();
        end
    endtask

    task automatic test_line_limits();
        idle_on = 1'b1;
        // one token filling the buffer: terminators land on the two last positions
        repeat (MAX_LINE) line_q.push_back(plain_char());
        line_q.push_back(clt_pkg::CH_NUL);
        send_line();
        // full token count, then the buffer is full too: the count is flagged first
        repeat (MAX_TOKENS) begin
            repeat (3) line_q.push_back(plain_char());
            line_q.push_back(clt_pkg::CH_SPACE);
        end
        line_q.push_back(plain_char());
        line_q.push_back(clt_pkg::CH_NUL);
        send_line();
        // one byte past the buffer
        repeat (MAX_LINE) line_q.push_back(plain_char());
        line_q.push_back(clt_pkg::CH_SPACE);
        line_q.push_back(plain_char());
        line_q.push_back(clt_pkg::CH_NUL);
        send_line();
        // exactly the token limit, ending cleanly
        repeat (MAX_TOKENS) begin
            line_q.push_back(plain_char());
            line_q.push_back(clt_pkg::CH_SPACE);
        end
        line_q.push_back(clt_pkg::CH_NUL);
        send_line();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        m_tready = 1'b0;
        clear_line_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_lines();
        test_random_lines(200, 1'b1);
        test_line_limits();
        idle_on = 1'b0;
        test_random_lines(100, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
